// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define SXP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sxp_pkg.sv =====
// ----------------------------------------------------------------------------
// sxp_pkg
// Character codes and shared types for the sexagesimal coordinate parser.
// ----------------------------------------------------------------------------
package sxp_pkg;

  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // degrees when the string ends right after the sign: (0-48)*10 + (0-48)
  localparam logic [31:0] DEG_EMPTY = 32'hFFFF_FDF0;

  typedef struct packed {
    logic hit;    // beat carries a character of this field
    logic clear;  // string ends on this beat
  } fld_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== design/sxp_field.sv =====
// ----------------------------------------------------------------------------
// sxp_field
// Two-character decimal field (minutes or seconds): leading digits only.
// ----------------------------------------------------------------------------
module sxp_field (
  input  logic             clk,
  input  logic             rst_n,
  input  sxp_pkg::fld_ctl_t ctl,
  input  logic [7:0]       char_code,
  output logic [6:0]       value_nxt
);
  import sxp_pkg::*;

  logic [6:0]  value_r;
  logic        open_r;
  logic        open_nxt;
  logic [10:0] wide;

  always_comb begin
    wide      = 11'({value_r, 3'b000}) + 11'({value_r, 1'b0})
              + 11'(char_code - CH_ZERO);
    value_nxt = value_r;
    open_nxt  = open_r;
    if (ctl.hit) begin
      if (open_r && is_digit(char_code)) begin
        value_nxt = wide[6:0];
      end else begin
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      value_r <= '0;
      open_r  <= 1'b1;
    end else begin
      value_r <= value_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// ===== design/sexagesimal_coordinate_parser.sv =====
// ----------------------------------------------------------------------------
// sexagesimal_coordinate_parser
// Parses "sDD*MM:SS" / "DDD*MM:SS" style strings into signed total seconds.
// ----------------------------------------------------------------------------
// Characters enter one per beat, one beat per cycle unless stalled. The beat
// marked in_last_char produces one result, registered, in the next cycle;
// every other beat produces none. All parsing state updates in the same
// cycle the character is taken, so the accumulator update plus the constant
// multiply by 3600 set the critical path. in_stall is raised only while a
// result sits in the output register and out_stall holds it there. After the
// last character the parser is back in its reset state for the next string.
module sexagesimal_coordinate_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_total_seconds
);
  import sxp_pkg::*;

  logic [3:0]  pos_r;
  logic        has_sign_r;
  logic        neg_r;
  logic [31:0] deg_r;
  logic [2:0]  ms_r;
  logic        out_valid_r;
  logic [31:0] out_total_r;

  logic        acc, fin;
  logic        p0, hs, neg, sign_beat, deg_hit, dig;
  logic [3:0]  d4, k, k2;
  logic [31:0] cval, deg_x10, deg_nxt, deg_f, prod, min60, secs, total;
  logic [2:0]  ms_nxt;
  logic [4:0]  len;
  logic        fld_zone;
  fld_ctl_t    min_ctl, sec_ctl;
  logic [6:0]  min_nxt, sec_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign fin      = acc && in_last_char;

  always_comb begin
    p0        = (pos_r == 4'd0);
    hs        = p0 ? (in_char_code == CH_MINUS || in_char_code == CH_PLUS) : has_sign_r;
    neg       = p0 ? (in_char_code == CH_MINUS) : neg_r;
    d4        = {3'b000, hs};
    sign_beat = p0 && hs;
    k         = pos_r - d4;
    deg_hit   = !sign_beat && (pos_r >= d4) && (k <= 4'd2);
    dig       = is_digit(in_char_code);
    cval      = {24'd0, in_char_code} - {24'd0, CH_ZERO};
    deg_x10   = {deg_r[28:0], 3'b000} + {deg_r[30:0], 1'b0} + cval;

    deg_nxt = deg_r;
    ms_nxt  = ms_r;
    if (deg_hit) begin
      unique case (k[1:0])
        2'd0: deg_nxt = cval;
        2'd1: deg_nxt = deg_x10;
        default: begin
          if (dig) begin
            deg_nxt = deg_x10;
            ms_nxt  = 3'(d4) + 3'd4;
          end else begin
            ms_nxt  = 3'(d4) + 3'd3;
          end
        end
      endcase
    end

    // minutes and seconds follow the degree field
    fld_zone = !sign_beat && !deg_hit && (ms_r != 3'd0) && (pos_r >= {1'b0, ms_r});
    k2       = pos_r - {1'b0, ms_r};
    min_ctl.hit   = acc && fld_zone && (k2 < 4'd2);
    sec_ctl.hit   = acc && fld_zone && (k2 == 4'd3 || k2 == 4'd4);
    min_ctl.clear = fin;
    sec_ctl.clear = fin;
  end

  always_comb begin
    // degree characters the string never reached count as code zero
    priority if (sign_beat) begin
      deg_f = DEG_EMPTY;
    end else if (deg_hit && k[1:0] == 2'd0) begin
      deg_f = {cval[28:0], 3'b000} + {cval[30:0], 1'b0} - {24'd0, CH_ZERO};
    end else begin
      deg_f = deg_nxt;
    end

    prod  = {deg_f[19:0], 12'd0} - {deg_f[22:0], 9'd0} + {deg_f[27:0], 4'd0};
    min60 = {19'd0, min_nxt, 6'd0} - {23'd0, min_nxt, 2'd0};
    len   = {1'b0, pos_r} + 5'd1;
    secs  = (len > ({2'b00, ms_nxt} + 5'd4)) ? {25'd0, sec_nxt} : 32'd0;
    total = prod + min60 + secs;
    if (neg) begin
      total = 32'd0 - total;
    end
  end

  sxp_field u_min (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (min_ctl),
    .char_code (in_char_code),
    .value_nxt (min_nxt)
  );

  sxp_field u_sec (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sec_ctl),
    .char_code (in_char_code),
    .value_nxt (sec_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      pos_r      <= '0;
      has_sign_r <= 1'b0;
      neg_r      <= 1'b0;
      deg_r      <= '0;
      ms_r       <= '0;
    end else if (acc) begin
      pos_r      <= (pos_r == 4'd15) ? pos_r : pos_r + 4'd1;
      has_sign_r <= hs;
      neg_r      <= neg;
      deg_r      <= deg_nxt;
      ms_r       <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_total_r <= total;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_total_seconds = out_total_r;

endmodule

// ===== design/sxp_checker.sv =====
// ----------------------------------------------------------------------------
// sxp_checker
// Port-level checks for the sexagesimal coordinate parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_char_code,
  input logic        in_last_char,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [31:0] out_total_seconds
);

  `SXP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_total_seconds), "stalled result beat changed")
  `SXP_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")
  `SXP_ASSERT_NEXT(a_last_gives_result, in_valid && !in_stall && in_last_char, out_valid, "last character gave no result")
  `SXP_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && !in_last_char && (!out_valid || !out_stall), !out_valid, "result without a last character")

endmodule

bind sexagesimal_coordinate_parser sxp_checker u_sxp_checker (.*);

// ===== tb/tb_sexagesimal_coordinate_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sexagesimal_coordinate_parser
// Sends coordinate strings to the parser one character per beat and checks
// each total-seconds result against a parse model kept in the bench. A short
// table of hand-picked strings comes first. Random strings follow, mostly
// well-formed with some noise. Both sides idle at random, and the output
// side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_sexagesimal_coordinate_parser;
  import sxp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RANDOM_CHARS    = 1400;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned IDLE_PCT        = 28;
  localparam int unsigned DIR_BEATS       = 22;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_char_code;
  logic               in_last_char;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_total_seconds;

  sexagesimal_coordinate_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_seconds(out_total_seconds)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [7:0]  code;
    logic        is_last;
    logic        known;    // seconds below is the expected total
    logic [31:0] seconds;
  } dir_beat_t;

  // Full signed string, a lone 0xFF, a lone plus sign, a minute field cut by
  // a non-digit with seconds too short to count, minus with short degrees,
  // a lone NUL.
  dir_beat_t directed_beats [0:DIR_BEATS-1] = '{
    '{CH_MINUS, 1'b0, 1'b0, 32'd0},
    '{"3",      1'b0, 1'b0, 32'd0},
    '{"5",      1'b0, 1'b0, 32'd0},
    '{"9",      1'b0, 1'b0, 32'd0},
    '{CH_STAR,  1'b0, 1'b0, 32'd0},
    '{"5",      1'b0, 1'b0, 32'd0},
    '{"9",      1'b0, 1'b0, 32'd0},
    '{CH_COLON, 1'b0, 1'b0, 32'd0},
    '{"5",      1'b0, 1'b0, 32'd0},
    '{"9",      1'b1, 1'b1, -32'sd1295999},
    '{8'hFF,    1'b1, 1'b0, 32'd0},
    '{CH_PLUS,  1'b1, 1'b1, -32'sd1900800},
    '{"1",      1'b0, 1'b0, 32'd0},
    '{"2",      1'b0, 1'b0, 32'd0},
    '{CH_COLON, 1'b0, 1'b0, 32'd0},
    '{"3",      1'b0, 1'b0, 32'd0},
    '{"a",      1'b0, 1'b0, 32'd0},
    '{CH_COLON, 1'b0, 1'b0, 32'd0},
    '{"9",      1'b1, 1'b0, 32'd0},
    '{CH_MINUS, 1'b0, 1'b0, 32'd0},
    '{"0",      1'b1, 1'b0, 32'd0},
    '{8'h00,    1'b1, 1'b0, 32'd0}
  };

  // parse model state
  logic [3:0]  ps_pos;
  logic        ps_has_sign;
  logic        ps_negative;
  logic [31:0] ps_degrees;
  logic [2:0]  ps_min_start;
  logic [6:0]  ps_minutes;
  logic        ps_min_open;
  logic [6:0]  ps_seconds;
  logic        ps_sec_open;

  logic [31:0] exp_seconds_q[$];
  logic [31:0] exp_head;

  int          errors          = 0;
  int          results_checked = 0;
  int          chars_sent      = 0;
  int          strings_sent    = 0;
  int          hold_cycles     = 0;
  int unsigned send_idle_pct   = IDLE_PCT;
  int unsigned recv_idle_pct   = IDLE_PCT;
  int unsigned cycle_count     = 0;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void clear_parse_state();
    ps_pos       = 4'd0;
    ps_has_sign  = 1'b0;
    ps_negative  = 1'b0;
    ps_degrees   = 32'd0;
    ps_min_start = 3'd0;
    ps_minutes   = 7'd0;
    ps_min_open  = 1'b1;
    ps_seconds   = 7'd0;
    ps_sec_open  = 1'b1;
  endfunction

  // k is the offset inside the degree field; the third slot decides where
  // the minutes begin
  function automatic void degree_char(input int k, input logic [7:0] c);
    logic [2:0] base;
    base = ps_has_sign ? 3'd1 : 3'd0;
    if (k == 0) begin
      ps_degrees = {24'd0, c} - {24'd0, CH_ZERO};
    end else if (k == 1) begin
      ps_degrees = ps_degrees * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
    end else if (is_numeral(c)) begin
      ps_degrees   = ps_degrees * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
      ps_min_start = base + 3'd4;
    end else begin
      ps_min_start = base + 3'd3;
    end
  endfunction

  function automatic void field_char(inout logic [6:0] value, inout logic open,
                                     input logic [7:0] c);
    logic [10:0] wide;
    if (open && is_numeral(c)) begin
      wide  = {4'd0, value} * 11'd10 + {3'd0, c - CH_ZERO};
      value = wide[6:0];
    end else begin
      open = 1'b0;
    end
  endfunction

  // returns 1 when the beat ends a string; total then holds the result
  function automatic logic parse_char(input logic [7:0] c, input logic is_last,
                                      output logic [31:0] total);
    int          p;
    int          d;
    int          k;
    int          len;
    int          q;
    logic [31:0] secs;
    p     = ps_pos;
    total = 32'd0;
    if (p == 0) begin
      ps_has_sign = (c == CH_MINUS) || (c == CH_PLUS);
      ps_negative = (c == CH_MINUS);
    end
    d = ps_has_sign ? 1 : 0;
    if (!(p == 0 && ps_has_sign)) begin
      if (p >= d && p <= d + 2) begin
        degree_char(p - d, c);
      end else if (ps_min_start != 3'd0 && p >= ps_min_start) begin
        k = p - ps_min_start;
        if (k < 2) begin
          field_char(ps_minutes, ps_min_open, c);
        end else if (k == 3 || k == 4) begin
          field_char(ps_seconds, ps_sec_open, c);
        end
      end
    end
    if (ps_pos != 4'd15) begin
      ps_pos = ps_pos + 4'd1;
    end
    if (!is_last) begin
      return 1'b0;
    end
    // degree slots the string never reached read as NUL
    len = p + 1;
    for (q = len; q <= d + 2; q++) begin
      degree_char(q - d, 8'd0);
    end
    secs  = (len > ps_min_start + 4) ? {25'd0, ps_seconds} : 32'd0;
    total = (ps_degrees * 32'd60 + {25'd0, ps_minutes}) * 32'd60 + secs;
    if (ps_negative) begin
      total = -total;
    end
    clear_parse_state();
    return 1'b1;
  endfunction

  function automatic logic [7:0] mostly_digit();
    if ($urandom_range(9) != 0) begin
      return CH_ZERO + 8'($urandom_range(9));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] separator();
    case ($urandom_range(4))
      0, 1:    return CH_STAR;
      2, 3:    return CH_COLON;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic char_q_t random_coordinate();
    char_q_t s;
    int      n;
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(2))
        0:       s.push_back(CH_MINUS);
        1:       s.push_back(CH_PLUS);
        default: ;
      endcase
      repeat ($urandom_range(3, 2)) s.push_back(CH_ZERO + 8'($urandom_range(9)));
      s.push_back(separator());
      repeat (2) s.push_back(mostly_digit());
      if ($urandom_range(9) < 6) begin
        s.push_back(separator());
        repeat (2) s.push_back(mostly_digit());
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(6, 1)) s.push_back(8'($urandom_range(255)));
      end
      // broken: cut short somewhere
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(s.size(), 1);
        while (s.size() > n) s.pop_back();
      end
    end else begin
      repeat ($urandom_range(20, 1)) begin
        s.push_back($urandom_range(1) ? mostly_digit() : 8'($urandom_range(255)));
      end
    end
    return s;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last,
                           input logic known, input logic [31:0] seconds);
    logic [31:0] total;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_char(c, is_last, total)) begin
      exp_seconds_q.push_back(known ? seconds : total);
    end
    chars_sent++;
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[i]) begin
      send_char(s[i], i == s.size() - 1, 1'b0, 32'd0);
    end
    strings_sent++;
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_seconds_q.size() == 0) begin
        $error("unexpected result beat: out_total_seconds %0d", out_total_seconds);
        errors++;
      end else begin
        exp_head = exp_seconds_q.pop_front();
        results_checked++;
        if (out_total_seconds !== exp_head) begin
          $error("out_total_seconds: expected %0d, actual %0d",
                 $signed(exp_head), out_total_seconds);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, exp_seconds_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic pressure_done;
    pressure_done = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = 8'd0;
    in_last_char  = 1'b0;
    clear_parse_state();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_beats[i]) begin
      send_char(directed_beats[i].code, directed_beats[i].is_last,
                directed_beats[i].known, directed_beats[i].seconds);
    end
    strings_sent += 6;

    while (chars_sent < RANDOM_CHARS + DIR_BEATS) begin
      if (!pressure_done && chars_sent >= 300) begin
        hold_cycles   = HOLD_OFF_CYCLES;
        pressure_done = 1'b1;
      end
      // a stretch where neither side idles
      if (chars_sent >= 700 && chars_sent < 1000) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
      end
      send_string(random_coordinate());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (exp_seconds_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d strings in %0d character beats; checked %0d results.",
             strings_sent, chars_sent, results_checked);
    $display("Covered signs, short and long strings, broken fields, noise, and a %0d-cycle "
             , HOLD_OFF_CYCLES, "output hold-off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
